@@ hw/rtl/miv_pkg.sv @@
package miv_pkg;

  localparam int KEY_BITS = 10;
  localparam int VIOL_BITS = 26;
  localparam int CMD_BITS = 3;
  localparam int STATUS_BITS = 2;

  localparam int KEY_COUNT_DEF = 1024;
  localparam longint unsigned COUNT_MAX_DEF = 64'd65535;

  localparam int QUEUE_DEPTH = 4;

  // key fold by reciprocal: q = (key * ceil(2^FOLD_SHIFT / n)) >> FOLD_SHIFT
  localparam int FOLD_SHIFT = 20;
  localparam int RECIP_BITS = 21;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD_L  = 3'd0,
    CMD_REM_L  = 3'd1,
    CMD_ADD_R  = 3'd2,
    CMD_REM_R  = 3'd3,
    CMD_REPL_L = 3'd4,
    CMD_REPL_R = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_EXEC,
    BK_REPL,
    BK_WRITE_OLD
  } back_state_t;

endpackage

@@ hw/rtl/multiset_inclusion_violation.sv @@
// channel | direction | handshake            | beat
// --------+-----------+----------------------+--------------------------------
// in      | input     | in_valid / in_ready  | cmd, key, new_key
// out     | output    | out_valid / out_ready| violation, is_subset, status
//
// add and remove beats pass through the back-end states FETCH and EXEC (count read, then update);
// replace adds REPL, and WRITE_OLD when applied, as each count table has a single
// write port (new key, then old key)
// the front end has an input register and feeds a 4-entry queue
// after reset both tables are cleared, one key per cycle, over all KEY_COUNT keys;
// in_ready stays low until the pass ends
// a result waiting in the output register stalls the back end; the front end goes on until the queue is full
module multiset_inclusion_violation #(
  parameter int              KEY_COUNT = miv_pkg::KEY_COUNT_DEF,
  parameter longint unsigned COUNT_MAX = miv_pkg::COUNT_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [miv_pkg::CMD_BITS-1:0]     cmd,
  input  logic [miv_pkg::KEY_BITS-1:0]     key,
  input  logic [miv_pkg::KEY_BITS-1:0]     new_key,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [miv_pkg::VIOL_BITS-1:0]    violation,
  output logic                             is_subset,
  output logic [miv_pkg::STATUS_BITS-1:0]  status
);

  localparam int KW = $clog2(KEY_COUNT);
  localparam int QW = miv_pkg::CMD_BITS + 2 * KW;

  logic                         busy;
  logic                         full;
  logic                         push;
  logic [miv_pkg::CMD_BITS-1:0] push_cmd;
  logic [KW-1:0]                push_key;
  logic [KW-1:0]                push_new_key;
  logic                         q_valid;
  logic                         q_pop;
  logic [QW-1:0]                q_data;

  miv_front #(.KEY_COUNT(KEY_COUNT)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .key          (key),
    .new_key      (new_key),
    .busy         (busy),
    .full         (full),
    .push         (push),
    .push_cmd     (push_cmd),
    .push_key     (push_key),
    .push_new_key (push_new_key)
  );

  miv_queue #(.WIDTH(QW), .DEPTH(miv_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_cmd, push_key, push_new_key}),
    .full  (full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_data)
  );

  miv_back #(.KEY_COUNT(KEY_COUNT), .COUNT_MAX(COUNT_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_data[QW-1 -: miv_pkg::CMD_BITS]),
    .q_key     (q_data[2*KW-1 -: KW]),
    .q_new_key (q_data[KW-1:0]),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .violation (violation),
    .is_subset (is_subset),
    .status    (status)
  );

endmodule

@@ hw/rtl/miv_ram.sv @@
module miv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/miv_queue.sv @@
module miv_queue #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full  = (fill == (AW + 1)'(DEPTH));
  assign valid = (fill != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (AW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/miv_front.sv @@
module miv_front #(
  parameter int KEY_COUNT = miv_pkg::KEY_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [miv_pkg::CMD_BITS-1:0]  cmd,
  input  logic [miv_pkg::KEY_BITS-1:0]  key,
  input  logic [miv_pkg::KEY_BITS-1:0]  new_key,
  input  logic                          busy,
  input  logic                          full,
  output logic                          push,
  output logic [miv_pkg::CMD_BITS-1:0]  push_cmd,
  output logic [$clog2(KEY_COUNT)-1:0]  push_key,
  output logic [$clog2(KEY_COUNT)-1:0]  push_new_key
);

  localparam int KW = $clog2(KEY_COUNT);
  localparam int KB = miv_pkg::KEY_BITS;

  logic          take;
  logic          s1_valid;
  logic [miv_pkg::CMD_BITS-1:0] s1_cmd;
  logic [KB-1:0] s1_key;
  logic [KB-1:0] s1_new_key;

  assign in_ready = !busy && (!s1_valid || !full);
  assign take     = in_valid && in_ready;
  assign push     = s1_valid && !full;
  assign push_cmd = s1_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take || (s1_valid && full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd     <= cmd;
      s1_key     <= key;
      s1_new_key <= new_key;
    end
  end

  generate
    if (KEY_COUNT < (1 << KB)) begin : g_fold
      localparam int RW = miv_pkg::RECIP_BITS;
      localparam logic [RW-1:0] RECIP =
        RW'(((1 << miv_pkg::FOLD_SHIFT) + KEY_COUNT - 1) / KEY_COUNT);
      localparam logic [KB-1:0] KC = KB'(KEY_COUNT);

      logic [KB+RW-1:0] prod_key;
      logic [KB+RW-1:0] prod_new;
      logic [KB-1:0]    q_key;
      logic [KB-1:0]    q_new;
      logic [2*KB-1:0]  back_key;
      logic [2*KB-1:0]  back_new;
      logic [2*KB-1:0]  rem_key;
      logic [2*KB-1:0]  rem_new;

      assign prod_key = {{RW{1'b0}}, key} * {{KB{1'b0}}, RECIP};
      assign prod_new = {{RW{1'b0}}, new_key} * {{KB{1'b0}}, RECIP};

      always_ff @(posedge clk) begin
        if (take) begin
          q_key <= prod_key[miv_pkg::FOLD_SHIFT +: KB];
          q_new <= prod_new[miv_pkg::FOLD_SHIFT +: KB];
        end
      end

      assign back_key = {{KB{1'b0}}, q_key} * {{KB{1'b0}}, KC};
      assign back_new = {{KB{1'b0}}, q_new} * {{KB{1'b0}}, KC};
      assign rem_key  = {{KB{1'b0}}, s1_key} - back_key;
      assign rem_new  = {{KB{1'b0}}, s1_new_key} - back_new;

      assign push_key     = rem_key[KW-1:0];
      assign push_new_key = rem_new[KW-1:0];
    end else if (KW > KB) begin : g_wide
      assign push_key     = {{(KW - KB){1'b0}}, s1_key};
      assign push_new_key = {{(KW - KB){1'b0}}, s1_new_key};
    end else begin : g_exact
      assign push_key     = s1_key;
      assign push_new_key = s1_new_key;
    end
  endgenerate

endmodule

@@ hw/rtl/miv_back.sv @@
module miv_back #(
  parameter int              KEY_COUNT = miv_pkg::KEY_COUNT_DEF,
  parameter longint unsigned COUNT_MAX = miv_pkg::COUNT_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  logic [miv_pkg::CMD_BITS-1:0]     q_cmd,
  input  logic [$clog2(KEY_COUNT)-1:0]     q_key,
  input  logic [$clog2(KEY_COUNT)-1:0]     q_new_key,
  output logic                             q_pop,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [miv_pkg::VIOL_BITS-1:0]    violation,
  output logic                             is_subset,
  output logic [miv_pkg::STATUS_BITS-1:0]  status
);

  localparam int KW = $clog2(KEY_COUNT);
  localparam int CW = $clog2(COUNT_MAX + 64'd1);
  localparam longint unsigned VMAX = 64'(KEY_COUNT) * COUNT_MAX;
  localparam int VW = $clog2(VMAX + 64'd1);
  localparam int OW = miv_pkg::VIOL_BITS;
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  miv_pkg::back_state_t state, state_next;

  logic [KW-1:0]   clr_addr;
  miv_pkg::cmd_t   cur_cmd;
  logic [KW-1:0]   cur_key;
  logic [KW-1:0]   cur_new_key;
  logic [CW-1:0]   old_l;
  logic [CW-1:0]   old_r;
  logic [VW-1:0]   total;
  logic [VW-1:0]   total_next;

  logic            we_l;
  logic            we_r;
  logic [KW-1:0]   waddr;
  logic [KW-1:0]   raddr;
  logic [CW-1:0]   wdata_l;
  logic [CW-1:0]   wdata_r;
  logic [CW-1:0]   rd_l;
  logic [CW-1:0]   rd_r;

  logic            out_ok;
  logic            emit;
  logic            capture;
  logic            left_side;
  logic            inc_a;
  logic            inc_b;
  logic            dec_a;
  logic            dec_b;
  logic [CW-1:0]   old_cnt;
  logic [CW-1:0]   new_cnt;
  logic [OW-1:0]   viol_sat;
  miv_pkg::status_t st;

  miv_ram #(.WIDTH(CW), .DEPTH(KEY_COUNT)) u_left (
    .clk   (clk),
    .we    (we_l),
    .waddr (waddr),
    .wdata (wdata_l),
    .raddr (raddr),
    .rdata (rd_l)
  );

  miv_ram #(.WIDTH(CW), .DEPTH(KEY_COUNT)) u_right (
    .clk   (clk),
    .we    (we_r),
    .waddr (waddr),
    .wdata (wdata_r),
    .raddr (raddr),
    .rdata (rd_r)
  );

  assign busy      = (state == miv_pkg::BK_CLEAR);
  assign out_ok    = !out_valid || out_ready;
  assign left_side = (cur_cmd == miv_pkg::CMD_REPL_L);
  assign old_cnt   = left_side ? old_l : old_r;
  assign new_cnt   = left_side ? rd_l : rd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= miv_pkg::BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    raddr      = cur_key;
    waddr      = cur_key;
    we_l       = 1'b0;
    we_r       = 1'b0;
    wdata_l    = rd_l;
    wdata_r    = rd_r;
    emit       = 1'b0;
    capture    = 1'b0;
    inc_a      = 1'b0;
    inc_b      = 1'b0;
    dec_a      = 1'b0;
    dec_b      = 1'b0;
    st         = miv_pkg::STAT_OK;
    case (state)
      miv_pkg::BK_CLEAR: begin
        waddr   = clr_addr;
        we_l    = 1'b1;
        we_r    = 1'b1;
        wdata_l = '0;
        wdata_r = '0;
        if (clr_addr == KW'(KEY_COUNT - 1)) begin
          state_next = miv_pkg::BK_FETCH;
        end
      end
      miv_pkg::BK_FETCH: begin
        raddr = q_key;
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = miv_pkg::BK_EXEC;
        end
      end
      miv_pkg::BK_EXEC: begin
        if (cur_cmd == miv_pkg::CMD_REPL_L || cur_cmd == miv_pkg::CMD_REPL_R) begin
          raddr      = cur_new_key;
          capture    = 1'b1;
          state_next = miv_pkg::BK_REPL;
        end else if (out_ok) begin
          emit       = 1'b1;
          state_next = miv_pkg::BK_FETCH;
          case (cur_cmd)
            miv_pkg::CMD_ADD_L: begin
              if (rd_l >= CMAX) begin
                st = miv_pkg::STAT_OVERFLOW;
              end else begin
                we_l    = 1'b1;
                wdata_l = rd_l + CW'(1);
                inc_a   = (rd_l >= rd_r);
              end
            end
            miv_pkg::CMD_REM_L: begin
              if (rd_l == '0) begin
                st = miv_pkg::STAT_EMPTY;
              end else begin
                we_l    = 1'b1;
                wdata_l = rd_l - CW'(1);
                dec_a   = (rd_l > rd_r);
              end
            end
            miv_pkg::CMD_ADD_R: begin
              if (rd_r >= CMAX) begin
                st = miv_pkg::STAT_OVERFLOW;
              end else begin
                we_r    = 1'b1;
                wdata_r = rd_r + CW'(1);
                dec_a   = (rd_l > rd_r);
              end
            end
            miv_pkg::CMD_REM_R: begin
              if (rd_r == '0) begin
                st = miv_pkg::STAT_EMPTY;
              end else begin
                we_r    = 1'b1;
                wdata_r = rd_r - CW'(1);
                inc_a   = (rd_l >= rd_r);
              end
            end
            default: begin
            end
          endcase
        end
      end
      miv_pkg::BK_REPL: begin
        raddr = cur_new_key;
        waddr = cur_new_key;
        if (out_ok) begin
          emit       = 1'b1;
          state_next = miv_pkg::BK_FETCH;
          if (old_cnt == '0) begin
            st = miv_pkg::STAT_EMPTY;
          end else if (cur_key != cur_new_key && new_cnt >= CMAX) begin
            st = miv_pkg::STAT_OVERFLOW;
          end else if (cur_key != cur_new_key) begin
            state_next = miv_pkg::BK_WRITE_OLD;
            if (left_side) begin
              we_l    = 1'b1;
              wdata_l = rd_l + CW'(1);
              dec_a   = (old_l > old_r);
              inc_b   = (rd_l >= rd_r);
            end else begin
              we_r    = 1'b1;
              wdata_r = rd_r + CW'(1);
              inc_a   = (old_l >= old_r);
              dec_b   = (rd_l > rd_r);
            end
          end
        end
      end
      miv_pkg::BK_WRITE_OLD: begin
        waddr      = cur_key;
        state_next = miv_pkg::BK_FETCH;
        if (left_side) begin
          we_l    = 1'b1;
          wdata_l = old_l - CW'(1);
        end else begin
          we_r    = 1'b1;
          wdata_r = old_r - CW'(1);
        end
      end
      default: begin
        state_next = miv_pkg::BK_FETCH;
      end
    endcase
  end

  assign total_next = total + VW'(inc_a) + VW'(inc_b) - VW'(dec_a) - VW'(dec_b);

  generate
    if (VW > OW) begin : g_sat
      assign viol_sat = (|total_next[VW-1:OW]) ? {OW{1'b1}} : total_next[OW-1:0];
    end else if (VW == OW) begin : g_same
      assign viol_sat = total_next;
    end else begin : g_ext
      assign viol_sat = {{(OW - VW){1'b0}}, total_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == miv_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + KW'(1);
      end
      if (emit) begin
        total     <= total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd     <= miv_pkg::cmd_t'(q_cmd);
      cur_key     <= q_key;
      cur_new_key <= q_new_key;
    end
    if (capture) begin
      old_l <= rd_l;
      old_r <= rd_r;
    end
    if (emit) begin
      violation <= viol_sat;
      is_subset <= (total_next == '0);
      status    <= st;
    end
  end

  a_subset_matches_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_subset == (total == '0)))
    else $error("is_subset disagrees with running total");

  a_single_write_outside_clear: assert property (@(posedge clk) disable iff (rst)
    (state != miv_pkg::BK_CLEAR) |-> !(we_l && we_r))
    else $error("both count tables written outside clearing pass");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == miv_pkg::BK_CLEAR) |-> (!out_valid && !q_pop))
    else $error("activity during clearing pass");

  a_write_old_follows_replace: assert property (@(posedge clk) disable iff (rst)
    (state == miv_pkg::BK_WRITE_OLD) |-> ($past(state) == miv_pkg::BK_REPL))
    else $error("old key write without replace");

endmodule

@@ verif/tb.sv @@
module tb;

  localparam int KEYS = miv_pkg::KEY_COUNT_DEF;
  localparam longint unsigned CMAX = miv_pkg::COUNT_MAX_DEF;
  localparam longint unsigned VIOL_CAP = (64'd1 << miv_pkg::VIOL_BITS) - 1;
  localparam logic [miv_pkg::CMD_BITS-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [miv_pkg::CMD_BITS-1:0] CMD_RSVD_B = 3'd7;
  localparam logic [miv_pkg::KEY_BITS-1:0] HOT_KEY = 10'd1000;
  localparam logic [miv_pkg::KEY_BITS-1:0] HOT_SRC_L = 10'd999;
  localparam logic [miv_pkg::KEY_BITS-1:0] HOT_SRC_R = 10'd998;

  class inclusion_tracker;
    typedef struct {
      logic [miv_pkg::VIOL_BITS-1:0]   violation;
      logic                            is_subset;
      logic [miv_pkg::STATUS_BITS-1:0] status;
    } result_t;

    longint unsigned tally [2][KEYS];
    longint unsigned excess_total;
    longint unsigned peak_excess;
    result_t due_results[$];
    int errors;
    int commands;
    int results;
    int stat_hits [4];

    function new();
      foreach (tally[s, k]) tally[s][k] = 0;
      foreach (stat_hits[i]) stat_hits[i] = 0;
      excess_total = 0;
      peak_excess = 0;
      errors = 0;
      commands = 0;
      results = 0;
    endfunction

    function longint unsigned excess(int k);
      return (tally[0][k] > tally[1][k]) ? tally[0][k] - tally[1][k] : 0;
    endfunction

    function void bump(int side, int k, bit up);
      excess_total -= excess(k);
      if (up) tally[side][k]++;
      else tally[side][k]--;
      excess_total += excess(k);
    endfunction

    function void take_command(logic [miv_pkg::CMD_BITS-1:0] c,
                               logic [miv_pkg::KEY_BITS-1:0] k_in,
                               logic [miv_pkg::KEY_BITS-1:0] nk_in);
      int k;
      int nk;
      int side;
      miv_pkg::status_t st;
      result_t r;
      k = int'(k_in) % KEYS;
      nk = int'(nk_in) % KEYS;
      side = (c == miv_pkg::CMD_ADD_L || c == miv_pkg::CMD_REM_L ||
              c == miv_pkg::CMD_REPL_L) ? 0 : 1;
      st = miv_pkg::STAT_OK;
      case (c)
        miv_pkg::CMD_ADD_L, miv_pkg::CMD_ADD_R: begin
          if (tally[side][k] >= CMAX) st = miv_pkg::STAT_OVERFLOW;
          else bump(side, k, 1'b1);
        end
        miv_pkg::CMD_REM_L, miv_pkg::CMD_REM_R: begin
          if (tally[side][k] == 0) st = miv_pkg::STAT_EMPTY;
          else bump(side, k, 1'b0);
        end
        miv_pkg::CMD_REPL_L, miv_pkg::CMD_REPL_R: begin
          if (tally[side][k] == 0) begin
            st = miv_pkg::STAT_EMPTY;
          end else if (k != nk && tally[side][nk] >= CMAX) begin
            st = miv_pkg::STAT_OVERFLOW;
          end else if (k != nk) begin
            bump(side, k, 1'b0);
            bump(side, nk, 1'b1);
          end
        end
        default: ;
      endcase
      r.violation = miv_pkg::VIOL_BITS'((excess_total > VIOL_CAP) ? VIOL_CAP : excess_total);
      r.is_subset = (excess_total == 0);
      r.status = st;
      due_results.push_back(r);
      if (excess_total > peak_excess) peak_excess = excess_total;
      commands++;
      stat_hits[st]++;
    endfunction

    function void match_result(logic [miv_pkg::VIOL_BITS-1:0] v, logic sub,
                               logic [miv_pkg::STATUS_BITS-1:0] st);
      result_t e;
      results++;
      if (due_results.size() == 0) begin
        $error("result beat with nothing pending: violation %0d status %0d", v, st);
        errors++;
        return;
      end
      e = due_results.pop_front();
      if (v !== e.violation) begin
        $error("violation: expected %0d, got %0d", e.violation, v);
        errors++;
      end
      if (sub !== e.is_subset) begin
        $error("is_subset: expected %0b, got %0b", e.is_subset, sub);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [miv_pkg::CMD_BITS-1:0] cmd;
  logic [miv_pkg::KEY_BITS-1:0] key;
  logic [miv_pkg::KEY_BITS-1:0] new_key;
  logic out_valid;
  logic out_ready;
  logic [miv_pkg::VIOL_BITS-1:0] violation;
  logic is_subset;
  logic [miv_pkg::STATUS_BITS-1:0] status;

  int in_rate = 0;
  int out_rate = 0;
  inclusion_tracker tracker = new();

  multiset_inclusion_violation dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .key(key),
    .new_key(new_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .violation(violation),
    .is_subset(is_subset),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: check each beat, stall in random bursts
  initial begin
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tracker.match_result(violation, is_subset, status);
      if (stall == 0 && $urandom_range(0, 99) < out_rate) stall = $urandom_range(1, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [miv_pkg::CMD_BITS-1:0] c,
                           logic [miv_pkg::KEY_BITS-1:0] k,
                           logic [miv_pkg::KEY_BITS-1:0] nk);
    int gap;
    gap = ($urandom_range(0, 99) < in_rate) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    new_key <= nk;
    do @(posedge clk); while (!in_ready);
    tracker.take_command(c, k, nk);
  endtask

  function automatic logic [miv_pkg::KEY_BITS-1:0] pick_key(int base);
    int q;
    q = $urandom_range(0, 99);
    if (q < 70) return miv_pkg::KEY_BITS'(base + $urandom_range(0, 7));
    if (q < 75) return HOT_KEY;
    return miv_pkg::KEY_BITS'($urandom_range(0, KEYS - 1));
  endfunction

  task automatic random_item(int base, int add_pct);
    int p;
    bit on_right;
    logic [miv_pkg::CMD_BITS-1:0] c;
    p = $urandom_range(0, 99);
    on_right = $urandom_range(0, 1);
    if (p < 3) c = ($urandom_range(0, 1) != 0) ? CMD_RSVD_A : CMD_RSVD_B;
    else if (p < add_pct) c = on_right ? miv_pkg::CMD_ADD_R : miv_pkg::CMD_ADD_L;
    else if (p < add_pct + 20) c = on_right ? miv_pkg::CMD_REPL_R : miv_pkg::CMD_REPL_L;
    else c = on_right ? miv_pkg::CMD_REM_R : miv_pkg::CMD_REM_L;
    send_item(c, pick_key(base), pick_key(base));
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= '0;
    key <= '0;
    new_key <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    in_rate = 20;
    out_rate = 20;
    send_item(miv_pkg::CMD_REM_L, 10'd0, 10'd0);
    send_item(miv_pkg::CMD_REM_R, 10'd1023, 10'd1023);
    send_item(miv_pkg::CMD_REPL_L, 10'h2AA, 10'h155);
    send_item(miv_pkg::CMD_REPL_R, 10'h155, 10'h2AA);
    send_item(CMD_RSVD_A, 10'd1023, 10'd0);
    send_item(CMD_RSVD_B, 10'd0, 10'd1023);
    send_item(miv_pkg::CMD_ADD_L, 10'd0, 10'd1023);
    send_item(miv_pkg::CMD_ADD_L, 10'd1023, 10'd0);
    send_item(miv_pkg::CMD_ADD_R, 10'd0, 10'd0);
    send_item(miv_pkg::CMD_ADD_R, 10'd0, 10'd0);
    send_item(miv_pkg::CMD_REPL_L, 10'd1023, 10'd1023);
    send_item(miv_pkg::CMD_REPL_L, 10'd1023, 10'd0);
    send_item(miv_pkg::CMD_REPL_R, 10'd0, 10'h2AA);
    send_item(miv_pkg::CMD_ADD_L, 10'h155, 10'd0);
    send_item(miv_pkg::CMD_REM_R, 10'h2AA, 10'd0);
    send_item(miv_pkg::CMD_REM_L, 10'h155, 10'd0);
    send_item(miv_pkg::CMD_REM_L, 10'd0, 10'd0);
    send_item(miv_pkg::CMD_REM_R, 10'd0, 10'd0);

    // replaces onto one hot key on both sides, and off it on the left side
    in_rate = 0;
    out_rate = 0;
    send_item(miv_pkg::CMD_ADD_L, HOT_KEY, 10'd0);
    send_item(miv_pkg::CMD_ADD_L, HOT_SRC_L, 10'd0);
    send_item(miv_pkg::CMD_REPL_L, HOT_SRC_L, HOT_KEY);
    send_item(miv_pkg::CMD_REPL_L, HOT_KEY, HOT_KEY);
    send_item(miv_pkg::CMD_ADD_R, HOT_KEY, 10'd0);
    send_item(miv_pkg::CMD_ADD_R, HOT_SRC_R, 10'd0);
    send_item(miv_pkg::CMD_REPL_R, HOT_SRC_R, HOT_KEY);
    send_item(miv_pkg::CMD_REPL_L, HOT_KEY, HOT_SRC_L);
    send_item(miv_pkg::CMD_REM_L, HOT_KEY, 10'd0);

    for (int seg = 0; seg < 9; seg++) begin
      int base;
      int add_pct;
      base = $urandom_range(0, KEYS - 1);
      add_pct = 30 + 15 * $urandom_range(0, 2);
      in_rate = (seg < 7) ? 10 * $urandom_range(0, 3) : 0;
      out_rate = (seg < 7) ? 10 * $urandom_range(0, 3) : 0;
      repeat (100) random_item(base, add_pct);
    end

    in_valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d commands and checked %0d results, peak violation %0d",
             tracker.commands, tracker.results, tracker.peak_excess);
    $display("outcomes: ok %0d, empty removals %0d, count overflows %0d",
             tracker.stat_hits[miv_pkg::STAT_OK], tracker.stat_hits[miv_pkg::STAT_EMPTY],
             tracker.stat_hits[miv_pkg::STAT_OVERFLOW]);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/miv_pkg.sv
hw/rtl/miv_ram.sv
hw/rtl/miv_queue.sv
hw/rtl/miv_front.sv
hw/rtl/miv_back.sv
hw/rtl/multiset_inclusion_violation.sv
verif/tb.sv
